/* rtl/core/six_position_accel_calibrator_core_assert.svh */
// Assertion macros shared by the calibrator core.
`ifndef SIX_POSITION_ACCEL_CALIBRATOR_CORE_ASSERT_SVH
`define SIX_POSITION_ACCEL_CALIBRATOR_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPAC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SPAC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/spac_pkg.sv */
// Shared types, constants and width helpers for the calibrator core.
package spac_pkg;

   localparam int DEF_AVG_COUNT = 10;
   localparam int DEF_ADC_BITS  = 10;
   localparam int DEF_FRAC_BITS = 12;

   localparam int PHASE_W = 4;
   localparam int G_W     = 16;
   localparam int TICK_W  = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int QUEUE_DEPTH = 2;

   // Result stream layout: phase, x_g, y_g, z_g from the lowest bit up.
   localparam int RSP_PAD_W  = 4;
   localparam int RSP_DATA_W = PHASE_W + 3 * G_W + RSP_PAD_W;
   localparam int RSP_USER_W = 2;

   localparam logic [PHASE_W-1:0] PHASE_FIRST    = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_LAST_CAP = 4'd6;
   localparam logic [PHASE_W-1:0] PHASE_HOLD     = 4'd7;
   localparam logic [PHASE_W-1:0] PHASE_RUN      = 4'd8;

   localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;
   localparam logic [TICK_W-1:0] WAIT_RESET = 16'd5000;
   localparam logic [TICK_W-1:0] HOLD_RESET = 16'd2000;

   localparam logic [G_W-1:0] G_MAX = 16'h7FFF;
   localparam logic [G_W-1:0] G_MIN = 16'h8000;
   localparam int G_POS_MAG = 32767;
   localparam int G_NEG_MAG = 32768;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [0:0] {
      REG_WAIT_MS = 1'b0,
      REG_HOLD_MS = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               conv;
   } job_ctrl_type;

   localparam int CTRL_W = $bits(job_ctrl_type);

   typedef struct packed {
      logic pop;
      logic start_div;
      logic busy;
   } back_status_type;

   // Width of one face sum: AVG_COUNT full-scale samples.
   function automatic int sum_width(int adc_bits, int avg_count);
      return $clog2(avg_count * ((1 << adc_bits) - 1) + 1);
   endfunction

endpackage

/* rtl/core/spac_queue.sv */
// Small job queue between the front and back ends.
module spac_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = spac_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             valid,
   output logic             full
);
   import spac_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign rdata = mem_ff[rd_ptr_ff];
   assign valid = (count_ff != '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/spac_div_lane.sv */
// One axis of the back end: bit-serial divider with rounding and saturation.
module spac_div_lane #(
   parameter int ADC_BITS  = spac_pkg::DEF_ADC_BITS,
   parameter int AVG_COUNT = spac_pkg::DEF_AVG_COUNT,
   parameter int FRAC_BITS = spac_pkg::DEF_FRAC_BITS,
   localparam int SUM_W = spac_pkg::sum_width(ADC_BITS, AVG_COUNT),
   localparam int NUM_W = SUM_W + 2,
   localparam int DEN_W = SUM_W + 1
) (
   input  logic                     clock,
   input  logic                     start,
   input  logic                     step,
   input  logic [NUM_W-1:0]         num,
   input  logic [DEN_W-1:0]         den,
   output logic [spac_pkg::G_W-1:0] g,
   output logic                     zero_den
);
   import spac_pkg::*;

   // Dividend is |num| * 2^(FRAC_BITS+1) + |den|, divided by 2*|den|.
   localparam int Q_W = SUM_W + FRAC_BITS + 3;

   logic [Q_W-1:0]   dq_ff, dq_in;
   logic [SUM_W:0]   rem_ff, rem_in;
   logic [SUM_W-1:0] ad_ff;
   logic             neg_res_ff, num_neg_ff, num_zero_ff, den_zero_ff;
   logic [NUM_W-1:0] an_full;
   logic [DEN_W-1:0] ad_full;
   logic [SUM_W+1:0] shifted, divisor2, diff;
   logic             fits;
   logic [G_W-1:0]   q_low;

   always_comb begin
      an_full  = num[NUM_W-1] ? -num : num;
      ad_full  = den[DEN_W-1] ? -den : den;
      shifted  = {rem_ff, dq_ff[Q_W-1]};
      divisor2 = {1'b0, ad_ff, 1'b0};
      fits     = (shifted >= divisor2);
      diff     = shifted - divisor2;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      if (start) begin
         dq_in  = Q_W'({an_full[SUM_W:0], {(FRAC_BITS + 1){1'b0}}})
                  + Q_W'(ad_full[SUM_W-1:0]);
         rem_in = '0;
      end else if (step) begin
         dq_in  = {dq_ff[Q_W-2:0], fits};
         rem_in = fits ? diff[SUM_W:0] : shifted[SUM_W:0];
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      if (start) begin
         ad_ff       <= ad_full[SUM_W-1:0];
         neg_res_ff  <= num[NUM_W-1] ^ den[DEN_W-1];
         num_neg_ff  <= num[NUM_W-1];
         num_zero_ff <= (num == '0);
         den_zero_ff <= (den == '0);
      end
   end

   always_comb begin
      q_low = dq_ff[G_W-1:0];
      if (den_zero_ff) begin
         g = num_zero_ff ? '0 : (num_neg_ff ? G_MIN : G_MAX);
      end else if (neg_res_ff) begin
         g = (dq_ff > Q_W'(G_NEG_MAG)) ? G_MIN : -q_low;
      end else begin
         g = (dq_ff > Q_W'(G_POS_MAG)) ? G_MAX : q_low;
      end
   end

   assign zero_den = den_zero_ff;

endmodule

/* rtl/core/spac_front.sv */
// Front end: takes items, runs the calibration sequence and queues jobs.
module spac_front #(
   parameter int ADC_BITS  = spac_pkg::DEF_ADC_BITS,
   parameter int AVG_COUNT = spac_pkg::DEF_AVG_COUNT,
   localparam int SUM_W      = spac_pkg::sum_width(ADC_BITS, AVG_COUNT),
   localparam int NUM_W      = SUM_W + 2,
   localparam int DEN_W      = SUM_W + 1,
   localparam int LANE_W     = NUM_W + DEN_W,
   localparam int MATH_W     = 3 * LANE_W,
   localparam int REQ_DATA_W = ((3 * ADC_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_DATA_W-1:0]       req_tdata,
   input  logic [1:0]                  req_tuser,
   input  logic [spac_pkg::TICK_W-1:0] wait_ms,
   input  logic [spac_pkg::TICK_W-1:0] hold_ms,
   input  logic                        q_full,
   output logic                        job_push,
   output spac_pkg::job_ctrl_type      job_ctrl,
   output logic [MATH_W-1:0]           job_math
);
   import spac_pkg::*;

   localparam int CNT_W = $clog2(AVG_COUNT + 1);

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [TICK_W-1:0]   ticks_ff, ticks_in, ticks_sat;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    sum_ff, sum_in, sum_acc;
   logic [SUM_W-1:0]    face_ff [6];
   logic                face_we;
   logic [2:0]          face_idx;
   logic                capturing;
   logic                accept;
   op_type              op;
   logic [ADC_BITS-1:0] raw [3];
   logic [ADC_BITS-1:0] raw_sel;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign job_push   = accept;
   assign op         = op_type'(req_tuser);

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [SUM_W:0] scaled;
      assign raw[a]  = req_tdata[a*ADC_BITS +: ADC_BITS];
      assign scaled  = (SUM_W + 1)'(raw[a]) * (SUM_W + 1)'(2 * AVG_COUNT);
      // Numerator 2*N*raw - P - Nneg and denominator P - Nneg for this axis.
      assign job_math[a*LANE_W +: NUM_W] = {1'b0, scaled}
                                           - {2'b00, face_ff[2*a]}
                                           - {2'b00, face_ff[2*a+1]};
      assign job_math[a*LANE_W+NUM_W +: DEN_W] = {1'b0, face_ff[2*a]}
                                                 - {1'b0, face_ff[2*a+1]};
   end

   always_comb begin
      face_idx  = phase_ff[2:0] - 3'd1;
      capturing = (phase_ff >= PHASE_FIRST) && (phase_ff <= PHASE_LAST_CAP);
      unique case (face_idx[2:1])
         2'd0:    raw_sel = raw[0];
         2'd1:    raw_sel = raw[1];
         default: raw_sel = raw[2];
      endcase
      sum_acc   = sum_ff + SUM_W'(raw_sel);
      ticks_sat = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + 1'b1;

      phase_in = phase_ff;
      ticks_in = ticks_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      face_we  = 1'b0;
      if (accept) begin
         unique case (op)
            OP_TICK: begin
               ticks_in = ticks_sat;
               if (phase_ff == PHASE_HOLD && ticks_sat >= hold_ms) begin
                  phase_in = PHASE_RUN;
               end
            end
            OP_RESTART: begin
               phase_in = PHASE_FIRST;
               ticks_in = '0;
               cnt_in   = '0;
               sum_in   = '0;
            end
            OP_SAMPLE: begin
               if (capturing && ticks_ff >= wait_ms) begin
                  if (cnt_ff == CNT_W'(AVG_COUNT - 1)) begin
                     face_we  = 1'b1;
                     sum_in   = '0;
                     cnt_in   = '0;
                     ticks_in = '0;
                     phase_in = phase_ff + 1'b1;
                  end else begin
                     sum_in = sum_acc;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      job_ctrl.phase = phase_in;
      job_ctrl.conv  = (op == OP_SAMPLE) && (phase_ff == PHASE_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         ticks_ff <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < 6; i++) begin
            face_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         if (face_we) begin
            face_ff[face_idx] <= sum_acc;
         end
      end
   end

endmodule

/* rtl/core/spac_back.sv */
// Back end: runs the three divider lanes and holds the result register.
module spac_back #(
   parameter int ADC_BITS  = spac_pkg::DEF_ADC_BITS,
   parameter int AVG_COUNT = spac_pkg::DEF_AVG_COUNT,
   parameter int FRAC_BITS = spac_pkg::DEF_FRAC_BITS,
   localparam int SUM_W    = spac_pkg::sum_width(ADC_BITS, AVG_COUNT),
   localparam int NUM_W    = SUM_W + 2,
   localparam int DEN_W    = SUM_W + 1,
   localparam int LANE_W   = NUM_W + DEN_W,
   localparam int Q_DATA_W = 3 * LANE_W + spac_pkg::CTRL_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  logic [Q_DATA_W-1:0]             q_rdata,
   output spac_pkg::back_status_type       back_status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [spac_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [spac_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import spac_pkg::*;

   localparam int Q_W   = SUM_W + FRAC_BITS + 3;
   localparam int CNT_W = $clog2(Q_W);

   back_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PHASE_W-1:0] job_phase_ff;
   job_ctrl_type       q_ctrl;
   logic               out_free, pop, start, step, load, load_conv;
   logic [G_W-1:0]     lane_g [3];
   logic [2:0]         lane_zero;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] rsp_phase_ff;
   logic               rsp_conv_ff, rsp_zero_ff;
   logic [G_W-1:0]     rsp_g_ff [3];

   assign q_ctrl = job_ctrl_type'(q_rdata[CTRL_W-1:0]);
   assign step   = (state_ff == BACK_DIV);

   for (genvar a = 0; a < 3; a++) begin : g_lane
      spac_div_lane #(
         .ADC_BITS  (ADC_BITS),
         .AVG_COUNT (AVG_COUNT),
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .start    (start),
         .step     (step),
         .num      (q_rdata[CTRL_W + a*LANE_W +: NUM_W]),
         .den      (q_rdata[CTRL_W + a*LANE_W + NUM_W +: DEN_W]),
         .g        (lane_g[a]),
         .zero_den (lane_zero[a])
      );
   end

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pop       = 1'b0;
      start     = 1'b0;
      load      = 1'b0;
      load_conv = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (q_valid) begin
               if (q_ctrl.conv) begin
                  pop      = 1'b1;
                  start    = 1'b1;
                  cnt_in   = CNT_W'(Q_W - 1);
                  state_in = BACK_DIV;
               end else if (out_free) begin
                  pop  = 1'b1;
                  load = 1'b1;
               end
            end
         end
         BACK_DIV: begin
            if (cnt_ff == '0) begin
               state_in = BACK_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         BACK_DONE: begin
            if (out_free) begin
               load      = 1'b1;
               load_conv = 1'b1;
               state_in  = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      back_status.pop       = pop;
      back_status.start_div = start;
      back_status.busy      = step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         job_phase_ff <= q_ctrl.phase;
      end
      if (load) begin
         rsp_phase_ff <= load_conv ? job_phase_ff : q_ctrl.phase;
         rsp_conv_ff  <= load_conv;
         rsp_zero_ff  <= load_conv && (lane_zero != '0);
         for (int i = 0; i < 3; i++) begin
            rsp_g_ff[i] <= load_conv ? lane_g[i] : '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_g_ff[2], rsp_g_ff[1], rsp_g_ff[0],
                        rsp_phase_ff};
   assign rsp_tuser  = {rsp_zero_ff, rsp_conv_ff};

endmodule

/* rtl/core/six_position_accel_calibrator_core.sv */
// Top level of the six-position accelerometer calibrator.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         tvalid/tready          tuser: operation; tdata: raw_x, raw_y, raw_z
//   rsp_     out        tvalid/tready          tuser: conv_valid, zero_scale; tdata: g values
//   csr_     in         psel/penable/pready    wait_ms at 0x0, hold_ms at 0x4
//
// Ticks, restarts, capture samples and ignored samples pass the front end
// combinationally into the job queue and reach rsp_ through the response
// register once the back end pops them. A runtime sample holds the back end
// while the three bit-serial divider lanes work one quotient bit per cycle.
// The two-entry job queue lets the front end keep taking items meanwhile.
// Reset is synchronous; it clears all control state and the six face sums.
// A stalled rsp_ side fills the queue and then drops req_tready.
`include "six_position_accel_calibrator_core_assert.svh"

module six_position_accel_calibrator_core #(
   parameter int AVG_COUNT = spac_pkg::DEF_AVG_COUNT,
   parameter int ADC_BITS  = spac_pkg::DEF_ADC_BITS,
   parameter int FRAC_BITS = spac_pkg::DEF_FRAC_BITS,
   localparam int REQ_DATA_W = ((3 * ADC_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: raw_x, raw_y, raw_z (ADC_BITS each), zero fill
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_DATA_W-1:0]           req_tdata,
   // req_tuser: operation
   input  logic [1:0]                      req_tuser,
   // rsp_tdata: phase, x_g, y_g, z_g, zero fill
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [spac_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: conv_valid, zero_scale
   output logic [spac_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [spac_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [spac_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [spac_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import spac_pkg::*;

   localparam int SUM_W    = sum_width(ADC_BITS, AVG_COUNT);
   localparam int LANE_W   = (SUM_W + 2) + (SUM_W + 1);
   localparam int MATH_W   = 3 * LANE_W;
   localparam int Q_DATA_W = MATH_W + CTRL_W;

   logic [TICK_W-1:0] wait_ms_ff, wait_ms_in;
   logic [TICK_W-1:0] hold_ms_ff, hold_ms_in;
   logic              csr_write;
   csr_reg_type       reg_sel;

   job_ctrl_type      job_ctrl;
   logic [MATH_W-1:0] job_math;
   logic              job_push;
   logic [Q_DATA_W-1:0] q_rdata;
   logic              q_valid, q_full;
   back_status_type   back_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      wait_ms_in = wait_ms_ff;
      hold_ms_in = hold_ms_ff;
      unique case (reg_sel)
         REG_WAIT_MS: begin
            csr_prdata = CSR_DATA_W'(wait_ms_ff);
            if (csr_write) begin
               wait_ms_in = csr_pwdata[TICK_W-1:0];
            end
         end
         REG_HOLD_MS: begin
            csr_prdata = CSR_DATA_W'(hold_ms_ff);
            if (csr_write) begin
               hold_ms_in = csr_pwdata[TICK_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ms_ff <= WAIT_RESET;
         hold_ms_ff <= HOLD_RESET;
      end else begin
         wait_ms_ff <= wait_ms_in;
         hold_ms_ff <= hold_ms_in;
      end
   end

   spac_front #(
      .ADC_BITS  (ADC_BITS),
      .AVG_COUNT (AVG_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .wait_ms    (wait_ms_ff),
      .hold_ms    (hold_ms_ff),
      .q_full     (q_full),
      .job_push   (job_push),
      .job_ctrl   (job_ctrl),
      .job_math   (job_math)
   );

   spac_queue #(
      .WIDTH (Q_DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata ({job_math, job_ctrl}),
      .pop   (back_status.pop),
      .rdata (q_rdata),
      .valid (q_valid),
      .full  (q_full)
   );

   spac_back #(
      .ADC_BITS  (ADC_BITS),
      .AVG_COUNT (AVG_COUNT),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_rdata     (q_rdata),
      .back_status (back_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   `SPAC_ASSERT_IMPLY(a_pop_needs_item, clock, reset, back_status.pop, q_valid, "pop from empty queue")
   `SPAC_ASSERT_NEXT(a_div_follows_start, clock, reset, back_status.start_div, back_status.busy, "divider did not start")
   `SPAC_ASSERT_IMPLY(a_unconverted_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[RSP_DATA_W-1:PHASE_W] == '0, "g fields set without conversion")
   `SPAC_ASSERT_IMPLY(a_zero_scale_conv, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0], "zero_scale without conversion")

endmodule
